@@ design/scanner_frame_deframer_macros.svh @@
// ----------------------------------------------------------------------------
// scanner_frame_deframer assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SCANNER_FRAME_DEFRAMER_MACROS_SVH
`define SCANNER_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, constants and helpers of the scanner frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int MAX_PAYLOAD  = 32;
    localparam int PACKET_BYTES = 36;
    localparam int PAY_AW       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W        = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W        = 6;
    localparam int PKT_AW       = $clog2(PACKET_BYTES);
    localparam int HDR_BYTES    = 4;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_IDLE = 2'd1;
    localparam logic [1:0] REQ_ERR  = 2'd2;

    localparam logic [7:0] BYTE_START = 8'h03;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LOW   = 8'h20;
    localparam logic [7:0] BYTE_HIGH  = 8'h7E;
    localparam logic [7:0] BYTE_QMARK = 8'h3F;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    localparam int FLG_PROTO = 0;
    localparam int FLG_OVER  = 1;
    localparam int FLG_NONPR = 2;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_DEDUP   = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [IDX_W-1:0] out_index;
        logic             out_last;
    } t_res;

    typedef enum logic [2:0] {
        MODE_TYPE = 3'd0,
        MODE_ZERO = 3'd1,
        MODE_LEN  = 3'd2,
        MODE_PAY  = 3'd3,
        MODE_RAW  = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_BYTE, S_LEN_RD, S_LEN_CHK, S_CMP_RD, S_CMP_CHK,
        S_DECIDE, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT, S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_CLEAR, OP_BYTE, OP_LEN_RD, OP_LEN_CHK, OP_CMP_RD,
        OP_CMP_CHK, OP_DECIDE, OP_EMIT_RD, OP_EMIT_LD, OP_EMIT_NEXT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic is_byte;
        logic is_idle;
        logic is_err;
        logic timeout;
        logic raw_open;
        logic false_start;
        logic pub_after;
        logic len_zero;
        logic idx_last;
        logic suppress;
        logic out_valid;
        logic out_fire;
    } t_sts;

    function automatic logic is_print(input logic [7:0] b);
        return (b >= BYTE_LOW) && (b <= BYTE_HIGH);
    endfunction

endpackage

@@ design/scanner_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// scanner_frame_deframer
// Scanner serial stream deframer: frames bytes, builds fixed packets, dedups.
// ----------------------------------------------------------------------------
//  channel  | handshake                      | payload
//  input    | i_in_valid / o_in_ready        | i_in_data  (t_req)
//  output   | o_out_valid / i_out_ready      | o_out_data (t_res)
//  config   | psel penable pwrite pready     | paddr pwdata prdata
//
//  One item at a time. A finished frame adds a length check and a compare
//  against the previous packet, then emits each item, where output stalls
//  can hold it; the registered reads of the payload and previous-packet stores
//  set these steps. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scanner_frame_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sfd_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sfd_pkg::t_res o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [15:0]   r_byte_timeout_ms;
    logic [15:0]   r_dedup_window_ms;
    sfd_pkg::t_cmd cmd;
    sfd_pkg::t_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_timeout_ms <= 16'd100;
            r_dedup_window_ms <= 16'd1500;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == sfd_pkg::CFG_DEDUP) begin
                r_dedup_window_ms <= pwdata[15:0];
            end else begin
                r_byte_timeout_ms <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == sfd_pkg::CFG_DEDUP) ? {16'h0000, r_dedup_window_ms}
                                                     : {16'h0000, r_byte_timeout_ms};

    sfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    sfd_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_in_data         (i_in_data),
        .i_byte_timeout_ms (r_byte_timeout_ms),
        .i_dedup_window_ms (r_dedup_window_ms),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_data        (o_out_data)
    );

endmodule

@@ design/sfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfd_ctrl
// Sequencer: item intake, parse step, packet compare and byte emission.
// ----------------------------------------------------------------------------
`include "scanner_frame_deframer_macros.svh"

module sfd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output sfd_pkg::t_cmd o_cmd,
    input  sfd_pkg::t_sts i_sts
);

    sfd_pkg::t_state r_state, n_state;
    logic            r_then_byte, n_then_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfd_pkg::S_IDLE;
            r_then_byte <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_then_byte <= n_then_byte;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_then_byte = r_then_byte;
        o_cmd.op    = sfd_pkg::OP_NONE;
        o_in_ready  = 1'b0;
        unique case (r_state)
            sfd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = sfd_pkg::OP_LOAD;
                    n_state  = sfd_pkg::S_EVAL;
                end
            end
            sfd_pkg::S_EVAL: begin
                priority if (i_sts.is_idle) begin
                    n_then_byte = 1'b0;
                    n_state     = i_sts.raw_open ? sfd_pkg::S_LEN_RD : sfd_pkg::S_IDLE;
                end else if (i_sts.is_err) begin
                    o_cmd.op = sfd_pkg::OP_CLEAR;
                    n_state  = sfd_pkg::S_IDLE;
                end else if (i_sts.is_byte) begin
                    priority if (i_sts.timeout && i_sts.raw_open) begin
                        n_then_byte = 1'b1;
                        n_state     = sfd_pkg::S_LEN_RD;
                    end else if (i_sts.timeout) begin
                        o_cmd.op = sfd_pkg::OP_CLEAR;
                        n_state  = sfd_pkg::S_BYTE;
                    end else begin
                        n_state = sfd_pkg::S_BYTE;
                    end
                end else begin
                    n_state = sfd_pkg::S_IDLE;
                end
            end
            sfd_pkg::S_BYTE: begin
                o_cmd.op = sfd_pkg::OP_BYTE;
                priority if (i_sts.false_start) begin
                    n_state = sfd_pkg::S_BYTE;
                end else if (i_sts.pub_after) begin
                    n_then_byte = 1'b0;
                    n_state     = sfd_pkg::S_LEN_RD;
                end else begin
                    n_state = sfd_pkg::S_IDLE;
                end
            end
            sfd_pkg::S_LEN_RD: begin
                o_cmd.op = sfd_pkg::OP_LEN_RD;
                n_state  = sfd_pkg::S_LEN_CHK;
            end
            sfd_pkg::S_LEN_CHK: begin
                o_cmd.op = sfd_pkg::OP_LEN_CHK;
                n_state  = i_sts.len_zero ? sfd_pkg::S_FINISH : sfd_pkg::S_CMP_RD;
            end
            sfd_pkg::S_CMP_RD: begin
                o_cmd.op = sfd_pkg::OP_CMP_RD;
                n_state  = sfd_pkg::S_CMP_CHK;
            end
            sfd_pkg::S_CMP_CHK: begin
                o_cmd.op = sfd_pkg::OP_CMP_CHK;
                n_state  = i_sts.idx_last ? sfd_pkg::S_DECIDE : sfd_pkg::S_CMP_RD;
            end
            sfd_pkg::S_DECIDE: begin
                o_cmd.op = sfd_pkg::OP_DECIDE;
                n_state  = i_sts.suppress ? sfd_pkg::S_FINISH : sfd_pkg::S_EMIT_RD;
            end
            sfd_pkg::S_EMIT_RD: begin
                o_cmd.op = sfd_pkg::OP_EMIT_RD;
                n_state  = sfd_pkg::S_EMIT_LD;
            end
            sfd_pkg::S_EMIT_LD: begin
                o_cmd.op = sfd_pkg::OP_EMIT_LD;
                n_state  = sfd_pkg::S_EMIT_WAIT;
            end
            sfd_pkg::S_EMIT_WAIT: begin
                if (i_sts.out_fire) begin
                    o_cmd.op = sfd_pkg::OP_EMIT_NEXT;
                    n_state  = i_sts.idx_last ? sfd_pkg::S_FINISH : sfd_pkg::S_EMIT_RD;
                end
            end
            sfd_pkg::S_FINISH: begin
                o_cmd.op = sfd_pkg::OP_CLEAR;
                n_state  = r_then_byte ? sfd_pkg::S_BYTE : sfd_pkg::S_IDLE;
            end
            default: begin
                n_state = sfd_pkg::S_IDLE;
            end
        endcase
    end

    `SFD_ASSERT_NOW(a_wait_has_item, r_state == sfd_pkg::S_EMIT_WAIT, i_sts.out_valid, "emit wait without item")
    `SFD_ASSERT_NOW(a_item_in_wait, i_sts.out_valid, r_state == sfd_pkg::S_EMIT_WAIT, "output item outside emit wait")
    `SFD_ASSERT_NEXT(a_single_false_start, r_state == sfd_pkg::S_BYTE && i_sts.false_start, !i_sts.false_start, "false start repeated")

endmodule

@@ design/sfd_datapath.sv @@
// ----------------------------------------------------------------------------
// sfd_datapath
// Parser state, payload store, previous packet store and output register.
// ----------------------------------------------------------------------------
module sfd_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfd_pkg::t_cmd i_cmd,
    output sfd_pkg::t_sts o_sts,
    input  sfd_pkg::t_req i_in_data,
    input  logic [15:0]   i_byte_timeout_ms,
    input  logic [15:0]   i_dedup_window_ms,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sfd_pkg::t_res o_out_data
);

    localparam logic [7:0] MAX_PAY8 = 8'(sfd_pkg::MAX_PAYLOAD);
    localparam logic [sfd_pkg::IDX_W-1:0] IDX_LAST = sfd_pkg::IDX_W'(sfd_pkg::PACKET_BYTES - 1);
    localparam logic [sfd_pkg::IDX_W-1:0] HDR = sfd_pkg::IDX_W'(sfd_pkg::HDR_BYTES);

    logic [7:0] r_pay_mem  [sfd_pkg::MAX_PAYLOAD];
    logic [7:0] r_prev_mem [sfd_pkg::PACKET_BYTES];

    sfd_pkg::t_req              r_item;
    sfd_pkg::t_mode             r_mode, n_mode;
    logic [7:0]                 r_exp, n_exp;
    logic [7:0]                 r_rc, n_rc;
    logic [2:0]                 r_flags, n_flags;
    logic [31:0]                r_last_time, n_last_time;
    logic [sfd_pkg::LEN_W-1:0]  r_len;
    logic [sfd_pkg::IDX_W-1:0]  r_idx;
    logic                       r_match;
    logic                       r_prev_valid;
    logic [31:0]                r_prev_time;
    logic [7:0]                 r_pay_rd, r_prev_rd;
    logic                       r_out_valid;
    sfd_pkg::t_res              r_out;

    logic                       pay_we;
    logic [sfd_pkg::PAY_AW-1:0] pay_waddr, pay_raddr;
    logic [7:0]                 pay_wdata;
    logic [sfd_pkg::IDX_W-1:0]  pay_j;
    logic [sfd_pkg::LEN_W-1:0]  len_min, len_calc;
    logic [7:0]                 rc_inc, ab_b, ab_rc;
    logic [2:0]                 ab_flags;
    logic                       ab_en;
    logic [7:0]                 pkt_byte;
    logic                       out_fire;
    logic [31:0]                gap_last, gap_prev;

    assign out_fire = r_out_valid && i_out_ready;
    assign rc_inc   = (r_rc < sfd_pkg::COUNT_MAX) ? r_rc + 8'd1 : r_rc;
    assign len_min  = (r_rc > MAX_PAY8) ? sfd_pkg::LEN_W'(sfd_pkg::MAX_PAYLOAD)
                                        : r_rc[sfd_pkg::LEN_W-1:0];
    assign len_calc = len_min - sfd_pkg::LEN_W'(!r_flags[sfd_pkg::FLG_PROTO]
                                               && r_pay_rd == sfd_pkg::BYTE_CR);
    assign pay_j    = r_idx - HDR;
    assign gap_last = r_item.now_ms - r_last_time;
    assign gap_prev = r_item.now_ms - r_prev_time;

    always_comb begin
        priority if (r_idx == '0) begin
            pkt_byte = 8'(r_len);
        end else if (r_idx == sfd_pkg::IDX_W'(1)) begin
            pkt_byte = 8'(r_flags);
        end else if (r_idx == sfd_pkg::IDX_W'(2)) begin
            pkt_byte = 8'h00;
        end else if (r_idx == sfd_pkg::IDX_W'(3)) begin
            pkt_byte = 8'h01;
        end else if (pay_j < sfd_pkg::IDX_W'(r_len)) begin
            pkt_byte = sfd_pkg::is_print(r_pay_rd) ? r_pay_rd : sfd_pkg::BYTE_QMARK;
        end else begin
            pkt_byte = 8'h00;
        end
    end

    // byte step and parser clear
    always_comb begin
        n_mode      = r_mode;
        n_exp       = r_exp;
        n_rc        = r_rc;
        n_flags     = r_flags;
        n_last_time = r_last_time;
        ab_en       = 1'b0;
        ab_b        = r_item.rx_byte;
        ab_rc       = r_rc;
        ab_flags    = r_flags;
        pay_we      = 1'b0;
        pay_waddr   = r_rc[sfd_pkg::PAY_AW-1:0];
        pay_wdata   = ab_b;
        if (i_cmd.op == sfd_pkg::OP_CLEAR) begin
            n_mode      = sfd_pkg::MODE_TYPE;
            n_exp       = '0;
            n_rc        = '0;
            n_flags     = '0;
            n_last_time = '0;
        end else if (i_cmd.op == sfd_pkg::OP_BYTE) begin
            n_last_time = r_item.now_ms;
            unique case (r_mode)
                sfd_pkg::MODE_TYPE: begin
                    if (r_item.rx_byte == sfd_pkg::BYTE_START) begin
                        n_mode = sfd_pkg::MODE_ZERO;
                    end else begin
                        n_mode   = sfd_pkg::MODE_RAW;
                        n_exp    = '0;
                        ab_en    = 1'b1;
                        ab_rc    = '0;
                        ab_flags = '0;
                    end
                end
                sfd_pkg::MODE_ZERO: begin
                    if (r_item.rx_byte == sfd_pkg::BYTE_ZERO) begin
                        n_mode = sfd_pkg::MODE_LEN;
                    end else begin
                        n_mode   = sfd_pkg::MODE_RAW;
                        n_exp    = '0;
                        ab_en    = 1'b1;
                        ab_b     = sfd_pkg::BYTE_START;
                        ab_rc    = '0;
                        ab_flags = '0;
                    end
                end
                sfd_pkg::MODE_LEN: begin
                    if (r_item.rx_byte == '0) begin
                        n_mode      = sfd_pkg::MODE_TYPE;
                        n_exp       = '0;
                        n_rc        = '0;
                        n_flags     = '0;
                        n_last_time = '0;
                    end else begin
                        n_mode  = sfd_pkg::MODE_PAY;
                        n_exp   = r_item.rx_byte;
                        n_rc    = '0;
                        n_flags = 3'b001;
                        n_flags[sfd_pkg::FLG_OVER] = r_item.rx_byte > MAX_PAY8;
                    end
                end
                sfd_pkg::MODE_PAY, sfd_pkg::MODE_RAW: begin
                    ab_en = 1'b1;
                end
                default: begin
                    n_mode      = sfd_pkg::MODE_TYPE;
                    n_exp       = '0;
                    n_rc        = '0;
                    n_flags     = '0;
                    n_last_time = '0;
                end
            endcase
            if (ab_en) begin
                pay_waddr = ab_rc[sfd_pkg::PAY_AW-1:0];
                pay_wdata = ab_b;
                n_flags   = ab_flags;
                if (ab_rc < MAX_PAY8) begin
                    pay_we = 1'b1;
                end else begin
                    n_flags[sfd_pkg::FLG_OVER] = 1'b1;
                end
                if (!sfd_pkg::is_print(ab_b) &&
                    (ab_flags[sfd_pkg::FLG_PROTO] || ab_b != sfd_pkg::BYTE_CR)) begin
                    n_flags[sfd_pkg::FLG_NONPR] = 1'b1;
                end
                n_rc = (ab_rc < sfd_pkg::COUNT_MAX) ? ab_rc + 8'd1 : ab_rc;
            end
        end
    end

    always_comb begin
        pay_raddr = pay_j[sfd_pkg::PAY_AW-1:0];
        if (i_cmd.op == sfd_pkg::OP_LEN_RD) begin
            pay_raddr = sfd_pkg::PAY_AW'(len_min - sfd_pkg::LEN_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            r_pay_mem[pay_waddr] <= pay_wdata;
        end
        r_pay_rd <= r_pay_mem[pay_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sfd_pkg::OP_EMIT_LD) begin
            r_prev_mem[r_idx[sfd_pkg::PKT_AW-1:0]] <= pkt_byte;
        end
        r_prev_rd <= r_prev_mem[r_idx[sfd_pkg::PKT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sfd_pkg::OP_LOAD) begin
            r_item <= i_in_data;
        end
        if (i_cmd.op == sfd_pkg::OP_LEN_CHK) begin
            r_len <= len_calc;
        end
        if (i_cmd.op == sfd_pkg::OP_EMIT_LD) begin
            r_out.out_byte  <= pkt_byte;
            r_out.out_index <= r_idx;
            r_out.out_last  <= r_idx == IDX_LAST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sfd_pkg::MODE_TYPE;
            r_exp        <= '0;
            r_rc         <= '0;
            r_flags      <= '0;
            r_last_time  <= '0;
            r_idx        <= '0;
            r_match      <= 1'b0;
            r_prev_valid <= 1'b0;
            r_prev_time  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_exp       <= n_exp;
            r_rc        <= n_rc;
            r_flags     <= n_flags;
            r_last_time <= n_last_time;
            if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                sfd_pkg::OP_LEN_CHK: begin
                    r_idx   <= '0;
                    r_match <= 1'b1;
                end
                sfd_pkg::OP_CMP_CHK: begin
                    r_match <= r_match && (pkt_byte == r_prev_rd);
                    if (r_idx != IDX_LAST) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                sfd_pkg::OP_DECIDE: begin
                    r_idx <= '0;
                end
                sfd_pkg::OP_EMIT_LD: begin
                    r_out_valid <= 1'b1;
                end
                sfd_pkg::OP_EMIT_NEXT: begin
                    if (r_idx == IDX_LAST) begin
                        r_prev_valid <= 1'b1;
                        r_prev_time  <= r_item.now_ms;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_sts.is_byte     = r_item.req_type == sfd_pkg::REQ_BYTE;
        o_sts.is_idle     = r_item.req_type == sfd_pkg::REQ_IDLE;
        o_sts.is_err      = r_item.req_type == sfd_pkg::REQ_ERR;
        o_sts.timeout     = (r_mode != sfd_pkg::MODE_TYPE) &&
                            (gap_last > {16'h0000, i_byte_timeout_ms});
        o_sts.raw_open    = (r_mode == sfd_pkg::MODE_RAW) && (r_rc != '0);
        o_sts.false_start = (r_mode == sfd_pkg::MODE_ZERO) &&
                            (r_item.rx_byte != sfd_pkg::BYTE_ZERO);
        o_sts.pub_after   = (r_mode == sfd_pkg::MODE_PAY) && (rc_inc >= r_exp);
        o_sts.len_zero    = len_calc == '0;
        o_sts.idx_last    = r_idx == IDX_LAST;
        o_sts.suppress    = r_prev_valid && r_match &&
                            (gap_prev < {16'h0000, i_dedup_window_ms});
        o_sts.out_valid   = r_out_valid;
        o_sts.out_fire    = out_fire;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
